FILE: design/snpt_pkg.sv
`default_nettype none
package snpt_pkg;

  localparam int unsigned CordicSteps = 14;

  localparam logic [15:0]        MinRangeReset   = 16'd120;
  localparam logic [15:0]        MaxRangeReset   = 16'd12000;
  localparam logic signed [15:0] StartAngleReset = -16'sd32768;
  localparam logic signed [15:0] AngleStepReset  = 16'sd182;
  localparam logic [13:0]        GateRadiusReset = 14'd12;
  localparam logic signed [13:0] StartXReset     = 14'sd250;
  localparam logic signed [13:0] StartYReset     = 14'sd250;

  // samples must lie beyond min range plus this margin
  localparam logic [16:0] RangeMargin = 17'd50;

  // CORDIC start value, gain compensated for 14 steps
  localparam logic signed [17:0] CordicGain = 18'sd19898;

  // 250 cm origin offset in the r*sin scale (250 * 327680)
  localparam logic signed [33:0] PixelOffset = 34'sd81920000;
  // 327680 = 5 * 2^16; divide by 5 as multiply by ceil(2^18/5) then shift by 18
  localparam logic signed [16:0] FifthRecip = 17'sd52429;
  localparam int unsigned        FifthShift = 18;

  typedef struct packed {
    logic signed [15:0] sin;
    logic signed [15:0] cos;
  } trig_t;

  typedef struct packed {
    logic signed [13:0] px;
    logic signed [13:0] py;
    logic [28:0]        d2;
  } point_t;

  typedef enum logic [1:0] {
    TRK_IDLE,
    TRK_CORDIC,
    TRK_POINT,
    TRK_FINISH
  } trk_state_e;

  typedef enum logic [2:0] {
    CFG_MIN_RANGE   = 3'd0,
    CFG_MAX_RANGE   = 3'd1,
    CFG_START_ANGLE = 3'd2,
    CFG_ANGLE_STEP  = 3'd3,
    CFG_GATE_RADIUS = 3'd4,
    CFG_START_X     = 3'd5,
    CFG_START_Y     = 3'd6
  } cfg_index_e;

  typedef enum logic [3:0] {
    PT_IDLE,
    PT_MUL_SIN,
    PT_ABS_X,
    PT_DIV_X,
    PT_SIGN_X,
    PT_MUL_COS,
    PT_ABS_Y,
    PT_DIV_Y,
    PT_SIGN_Y,
    PT_SQ_X,
    PT_SQ_Y,
    PT_SUM
  } pt_step_e;

  // arctangent of 2^-i in binary angle units
  function automatic logic [13:0] atan_lut(input logic [3:0] idx);
    logic [13:0] val;
    case (idx)
      4'd0:    val = 14'd8192;
      4'd1:    val = 14'd4836;
      4'd2:    val = 14'd2555;
      4'd3:    val = 14'd1297;
      4'd4:    val = 14'd651;
      4'd5:    val = 14'd326;
      4'd6:    val = 14'd163;
      4'd7:    val = 14'd81;
      4'd8:    val = 14'd41;
      4'd9:    val = 14'd20;
      4'd10:   val = 14'd10;
      4'd11:   val = 14'd5;
      4'd12:   val = 14'd3;
      4'd13:   val = 14'd1;
      default: val = 14'd0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

FILE: design/snpt_cordic.sv
`default_nettype none
module snpt_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [15:0]  angle_i,
  output logic                done_o,
  output snpt_pkg::trig_t     trig_o
);
  import snpt_pkg::*;

  logic signed [17:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [3:0]         step_q, step_d;
  logic               busy_q, busy_d, done_q, done_d, neg_q, neg_d;

  logic signed [16:0] ang_ext, ang_fold;
  logic               fold;
  logic signed [17:0] sh_x, sh_y, atan_ext;
  logic signed [15:0] cx, cy;
  logic               last_step;

  // fold angles beyond a quarter turn by a half turn, negate results later
  always_comb begin
    ang_ext = {angle_i[15], angle_i};
    fold    = 1'b0;
    ang_fold = ang_ext;
    if (ang_ext > 17'sd16384) begin
      ang_fold = ang_ext - 17'sd32768;
      fold     = 1'b1;
    end else if (ang_ext < -17'sd16384) begin
      ang_fold = ang_ext + 17'sd32768;
      fold     = 1'b1;
    end
  end

  assign sh_x      = x_q >>> step_q;
  assign sh_y      = y_q >>> step_q;
  assign atan_ext  = {4'b0, atan_lut(step_q)};
  assign last_step = (step_q == 4'(CordicSteps - 1));

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    step_d = step_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = CordicGain;
      y_d    = '0;
      z_d    = {ang_fold[16], ang_fold};
      step_d = '0;
      busy_d = 1'b1;
      neg_d  = fold;
    end else if (busy_q) begin
      if (!z_q[17]) begin
        x_d = x_q - sh_y;
        y_d = y_q + sh_x;
        z_d = z_q - atan_ext;
      end else begin
        x_d = x_q + sh_y;
        y_d = y_q - sh_x;
        z_d = z_q + atan_ext;
      end
      step_d = step_q + 4'd1;
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    neg_q <= neg_d;
  end

  // clamp to +-32767, then undo the fold
  always_comb begin
    if (x_q > 18'sd32767) begin
      cx = 16'sd32767;
    end else if (x_q < -18'sd32767) begin
      cx = -16'sd32767;
    end else begin
      cx = x_q[15:0];
    end
    if (y_q > 18'sd32767) begin
      cy = 16'sd32767;
    end else if (y_q < -18'sd32767) begin
      cy = -16'sd32767;
    end else begin
      cy = y_q[15:0];
    end
  end

  assign trig_o.cos = neg_q ? -cx : cx;
  assign trig_o.sin = neg_q ? -cy : cy;
  assign done_o     = done_q;

endmodule
`default_nettype wire

FILE: design/snpt_point.sv
`default_nettype none
module snpt_point (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [15:0]         range_i,
  input  snpt_pkg::trig_t     trig_i,
  input  logic signed [13:0]  tracked_x_i,
  input  logic signed [13:0]  tracked_y_i,
  output logic                done_o,
  output snpt_pkg::point_t    point_o
);
  import snpt_pkg::*;

  pt_step_e           step_q, step_d;
  logic signed [33:0] prod_q, mul;
  logic signed [16:0] op_a, op_b;
  logic [15:0]        v_q;
  logic               neg_q;
  logic signed [13:0] px_q, py_q;
  logic [28:0]        acc_q;
  logic               done_q;

  logic signed [33:0] biased, mag;
  logic signed [13:0] quot, quot_s;
  logic signed [14:0] dx, dy;

  assign biased = PixelOffset + prod_q;
  assign mag    = biased[33] ? -biased : biased;
  assign quot   = {1'b0, prod_q[FifthShift+12:FifthShift]};
  assign quot_s = neg_q ? -quot : quot;
  assign dx     = {px_q[13], px_q} - {tracked_x_i[13], tracked_x_i};
  assign dy     = {py_q[13], py_q} - {tracked_y_i[13], tracked_y_i};

  // one shared multiplier, operands picked by the step
  always_comb begin
    case (step_q)
      PT_MUL_SIN: begin
        op_a = {1'b0, range_i};
        op_b = {trig_i.sin[15], trig_i.sin};
      end
      PT_MUL_COS: begin
        op_a = {1'b0, range_i};
        op_b = {trig_i.cos[15], trig_i.cos};
      end
      PT_DIV_X, PT_DIV_Y: begin
        op_a = {1'b0, v_q};
        op_b = FifthRecip;
      end
      PT_SQ_X: begin
        op_a = {{2{dx[14]}}, dx};
        op_b = {{2{dx[14]}}, dx};
      end
      PT_SQ_Y: begin
        op_a = {{2{dy[14]}}, dy};
        op_b = {{2{dy[14]}}, dy};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul = op_a * op_b;

  always_comb begin
    case (step_q)
      PT_IDLE:    step_d = start_i ? PT_MUL_SIN : PT_IDLE;
      PT_MUL_SIN: step_d = PT_ABS_X;
      PT_ABS_X:   step_d = PT_DIV_X;
      PT_DIV_X:   step_d = PT_SIGN_X;
      PT_SIGN_X:  step_d = PT_MUL_COS;
      PT_MUL_COS: step_d = PT_ABS_Y;
      PT_ABS_Y:   step_d = PT_DIV_Y;
      PT_DIV_Y:   step_d = PT_SIGN_Y;
      PT_SIGN_Y:  step_d = PT_SQ_X;
      PT_SQ_X:    step_d = PT_SQ_Y;
      PT_SQ_Y:    step_d = PT_SUM;
      default:    step_d = PT_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= PT_IDLE;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= (step_q == PT_SUM);
    end
  end

  always_ff @(posedge clk_i) begin
    case (step_q)
      PT_MUL_SIN, PT_MUL_COS, PT_DIV_X, PT_DIV_Y, PT_SQ_X: begin
        prod_q <= mul;
      end
      PT_ABS_X, PT_ABS_Y: begin
        // drop the 2^16 part of the scale; the divide by 5 follows
        v_q   <= mag[31:16];
        neg_q <= biased[33];
      end
      PT_SIGN_X: px_q <= quot_s;
      PT_SIGN_Y: py_q <= quot_s;
      PT_SQ_Y: begin
        acc_q  <= {1'b0, prod_q[27:0]};
        prod_q <= mul;
      end
      PT_SUM: acc_q <= acc_q + {1'b0, prod_q[27:0]};
      default: ;
    endcase
  end

  assign done_o     = done_q;
  assign point_o.px = px_q;
  assign point_o.py = py_q;
  assign point_o.d2 = acc_q;

endmodule
`default_nettype wire

FILE: design/scan_nearest_point_tracker_unit.sv
`default_nettype none
// Nearest-point tracker for laser range scans. Each stream item is one range
// sample in mm (tdata) with tlast on the final sample of a scan. Samples
// strictly between min_range+50 and max_range are turned into plane points in
// cm around (250,250), and the point nearest the tracked point, strictly
// inside the gate radius, is kept (first of equal points wins). At the end of
// a scan one result goes out: target x/y in tdata and found in tuser; it also
// becomes the new tracked point ((0,0) with found low if nothing was in the
// gate). A sample in range runs through the 14-step iterative CORDIC and then
// an 11-step sequence on one shared 17x17 multiplier; a sample out of range
// skips both and goes straight to the finish state. The input is not ready
// while a sample is in work. A finished result sits in an output register so
// the next samples are taken while it waits; a scan end stalls only if the
// previous result is still pending. Configuration writes are always accepted;
// writing start_x or start_y also loads the tracked point.
module scan_nearest_point_tracker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] distance_mm
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [13:0] target_x, [27:14] target_y, [31:28] zero
  output logic        m_axis_tuser,   // [0] found
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import snpt_pkg::*;

  logic [15:0]        min_range_q, max_range_q;
  logic signed [15:0] start_angle_q, angle_step_q;
  logic [13:0]        gate_radius_q;

  logic signed [15:0] beam_angle_q, angle_cur;
  logic signed [13:0] tracked_x_q, tracked_y_q, best_x_q, best_y_q;
  logic [28:0]        best_dist_q;
  logic               have_best_q, in_scan_q;

  logic [15:0]        range_q;
  logic               last_q;

  logic               out_valid_q, out_found_q;
  logic signed [13:0] out_x_q, out_y_q;

  trk_state_e         state_q, state_d;

  logic               accept, in_range, cfg_we;
  logic               cordic_start, cordic_done, point_start, point_done;
  logic               best_upd, out_load;
  logic [27:0]        gate_sq;
  trig_t              trig;
  point_t             point;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign cfg_we    = cfg_valid_i && cfg_ready_o;
  assign angle_cur = in_scan_q ? beam_angle_q : start_angle_q;
  assign in_range  = (({1'b0, min_range_q} + RangeMargin) < {1'b0, s_axis_tdata})
                     && (s_axis_tdata < max_range_q);
  assign gate_sq   = gate_radius_q * gate_radius_q;

  snpt_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (angle_cur),
    .done_o  (cordic_done),
    .trig_o  (trig)
  );

  snpt_point u_point (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (point_start),
    .range_i     (range_q),
    .trig_i      (trig),
    .tracked_x_i (tracked_x_q),
    .tracked_y_i (tracked_y_q),
    .done_o      (point_done),
    .point_o     (point)
  );

  always_comb begin
    case (state_q)
      TRK_IDLE: begin
        if (accept) begin
          state_d = in_range ? TRK_CORDIC : TRK_FINISH;
        end else begin
          state_d = TRK_IDLE;
        end
      end
      TRK_CORDIC: state_d = cordic_done ? TRK_POINT : TRK_CORDIC;
      TRK_POINT:  state_d = point_done ? TRK_FINISH : TRK_POINT;
      TRK_FINISH: state_d = (!last_q || out_load) ? TRK_IDLE : TRK_FINISH;
      default:    state_d = TRK_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    cordic_start  = 1'b0;
    point_start   = 1'b0;
    best_upd      = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      TRK_IDLE: begin
        s_axis_tready = 1'b1;
        cordic_start  = accept && in_range;
      end
      TRK_CORDIC: point_start = cordic_done;
      TRK_POINT:  best_upd = point_done && (point.d2 < best_dist_q);
      TRK_FINISH: out_load = last_q && (!out_valid_q || m_axis_tready);
      default: ;
    endcase
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= TRK_IDLE;
      min_range_q   <= MinRangeReset;
      max_range_q   <= MaxRangeReset;
      start_angle_q <= StartAngleReset;
      angle_step_q  <= AngleStepReset;
      gate_radius_q <= GateRadiusReset;
      tracked_x_q   <= StartXReset;
      tracked_y_q   <= StartYReset;
      beam_angle_q  <= StartAngleReset;
      best_x_q      <= '0;
      best_y_q      <= '0;
      best_dist_q   <= {15'b0, GateRadiusReset} * {15'b0, GateRadiusReset};
      have_best_q   <= 1'b0;
      in_scan_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we) begin
        case (cfg_index_i)
          CFG_MIN_RANGE:   min_range_q   <= cfg_data_i;
          CFG_MAX_RANGE:   max_range_q   <= cfg_data_i;
          CFG_START_ANGLE: start_angle_q <= cfg_data_i;
          CFG_ANGLE_STEP:  angle_step_q  <= cfg_data_i;
          CFG_GATE_RADIUS: gate_radius_q <= cfg_data_i[13:0];
          CFG_START_X:     tracked_x_q   <= cfg_data_i[13:0];
          CFG_START_Y:     tracked_y_q   <= cfg_data_i[13:0];
          default: ;
        endcase
      end

      if (accept) begin
        beam_angle_q <= angle_cur + angle_step_q;
        in_scan_q    <= 1'b1;
        // open a new scan on its first sample
        if (!in_scan_q) begin
          best_dist_q <= {1'b0, gate_sq};
          best_x_q    <= '0;
          best_y_q    <= '0;
          have_best_q <= 1'b0;
        end
      end

      if (best_upd) begin
        best_dist_q <= point.d2;
        best_x_q    <= point.px;
        best_y_q    <= point.py;
        have_best_q <= 1'b1;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
        tracked_x_q <= best_x_q;
        tracked_y_q <= best_y_q;
        in_scan_q   <= 1'b0;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      range_q <= s_axis_tdata;
      last_q  <= s_axis_tlast;
    end
    if (out_load) begin
      out_x_q     <= best_x_q;
      out_y_q     <= best_y_q;
      out_found_q <= have_best_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_y_q, out_x_q};
  assign m_axis_tuser  = out_found_q;

endmodule
`default_nettype wire

FILE: bench/scan_nearest_point_tracker_unit_test.sv
`timescale 1ns / 100ps
module scan_nearest_point_tracker_unit_test;
  import snpt_pkg::*;

  localparam int ItemsTarget  = 1650;
  localparam int SettleCycles = 40;
  localparam int HoldCycles   = 600;
  localparam int CycleLimit   = 600000;
  localparam int IdlePct      = 34;
  localparam int ReportLimit  = 10;

  typedef struct packed {
    logic signed [13:0] x;
    logic signed [13:0] y;
    logic               found;
  } target_fix_t;

  typedef enum logic {STEP_CFG, STEP_SAMPLE} step_kind_e;

  typedef struct {
    step_kind_e  kind;
    cfg_index_e  reg_idx;
    logic [15:0] value;
    logic        last;
    bit          typed;
    target_fix_t fix;
  } plan_step_t;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        s_tvalid  = 1'b0;
  wire         s_tready;
  logic [15:0] s_tdata   = '0;
  logic        s_tlast   = 1'b0;
  wire         m_tvalid;
  logic        m_tready  = 1'b0;
  wire  [31:0] m_tdata;
  wire         m_tuser;
  logic        cfg_valid = 1'b0;
  wire         cfg_ready;
  cfg_index_e  cfg_index = CFG_MIN_RANGE;
  logic [15:0] cfg_data  = '0;

  // tracker copy: configuration
  logic [15:0]        min_range   = 16'd120;
  logic [15:0]        max_range   = 16'd12000;
  logic [15:0]        scan_start  = 16'h8000;
  logic [15:0]        beam_step   = 16'd182;
  logic [13:0]        gate        = 14'd12;
  logic signed [13:0] home_x      = 14'sd250;
  logic signed [13:0] home_y      = 14'sd250;
  // tracker copy: scan state
  logic [15:0]        beam        = 16'h8000;
  int                 trk_x       = 250;
  int                 trk_y       = 250;
  int                 best_x      = 0;
  int                 best_y      = 0;
  logic [31:0]        best_d2     = 32'd144;
  bit                 have_best   = 1'b0;
  bit                 scan_open   = 1'b0;

  int atan_units [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};

  target_fix_t pending_targets [$];
  int          errors     = 0;
  int          sent       = 0;
  int          cycles     = 0;
  int          hold_count = 0;
  bit          hold_req   = 1'b0;
  bit          calm       = 1'b0;

  scan_nearest_point_tracker_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= ReportLimit) $display("%s", msg);
  endfunction

  function automatic void queue_target(input target_fix_t fix);
    pending_targets = {pending_targets, fix};
  endfunction

  // Q1.15 sine and cosine of a binary angle, iterative rotation
  function automatic void beam_sin_cos(input logic [15:0] ang, output int s, output int c);
    int a, x, y, z, dx, dy;
    bit flip;
    a = int'($signed(ang));
    flip = 1'b0;
    if (a > 16384) begin
      a = a - 32768;
      flip = 1'b1;
    end else if (a < -16384) begin
      a = a + 32768;
      flip = 1'b1;
    end
    x = 19898;
    y = 0;
    z = a;
    for (int i = 0; i < 14; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_units[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_units[i];
      end
    end
    if (x > 32767) x = 32767;
    if (x < -32767) x = -32767;
    if (y > 32767) y = 32767;
    if (y < -32767) y = -32767;
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endfunction

  // 250 cm offset plus r*f scaled to cm, truncated toward zero
  function automatic int plane_coord(input logic [15:0] r, input int f);
    longint p;
    p = 64'sd81920000 + longint'(r) * longint'(f);
    return int'(p / 64'sd327680);
  endfunction

  function automatic bit track_sample(input logic [15:0] r, input logic last,
                                      output target_fix_t fix);
    int s, c, px, py;
    longint dx, dy;
    logic [31:0] d2;
    if (!scan_open) begin
      beam      = scan_start;
      best_d2   = {18'd0, gate} * {18'd0, gate};
      best_x    = 0;
      best_y    = 0;
      have_best = 1'b0;
      scan_open = 1'b1;
    end
    if (({16'd0, min_range} + 32'd50 < {16'd0, r}) && (r < max_range)) begin
      beam_sin_cos(beam, s, c);
      px = plane_coord(r, s);
      py = plane_coord(r, c);
      dx = px - trk_x;
      dy = py - trk_y;
      d2 = 32'(dx * dx + dy * dy);
      // strict compare keeps the first of equally near points
      if (d2 < best_d2) begin
        best_d2   = d2;
        best_x    = px;
        best_y    = py;
        have_best = 1'b1;
      end
    end
    beam = beam + beam_step;
    fix = '0;
    if (!last) return 1'b0;
    fix.x     = best_x[13:0];
    fix.y     = best_y[13:0];
    fix.found = have_best;
    trk_x     = best_x;
    trk_y     = best_y;
    scan_open = 1'b0;
    return 1'b1;
  endfunction

  function automatic void apply_reg(input cfg_index_e idx, input logic [15:0] v);
    case (idx)
      CFG_MIN_RANGE:   min_range  = v;
      CFG_MAX_RANGE:   max_range  = v;
      CFG_START_ANGLE: scan_start = v;
      CFG_ANGLE_STEP:  beam_step  = v;
      CFG_GATE_RADIUS: gate       = v[13:0];
      CFG_START_X: begin
        home_x = v[13:0];
        trk_x  = home_x;
      end
      CFG_START_Y: begin
        home_y = v[13:0];
        trk_y  = home_y;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] pick_reg(input cfg_index_e idx);
    int mode;
    mode = $urandom_range(15);
    if (mode == 0) return 16'($urandom);
    case (idx)
      CFG_MIN_RANGE:
        return (mode == 1) ? 16'hFFFF : (mode == 2) ? 16'h0000 : 16'($urandom_range(400));
      CFG_MAX_RANGE:
        return (mode == 1) ? 16'hFFFF : (mode == 2) ? 16'h0000
                                      : 16'($urandom_range(65535, 3000));
      CFG_START_ANGLE, CFG_ANGLE_STEP:
        return (mode == 1) ? 16'h8000 : (mode == 2) ? 16'h7FFF : (mode == 3) ? 16'h0000
                                      : 16'($urandom_range(4000) - 2000);
      CFG_GATE_RADIUS:
        return (mode == 1) ? 16'h3FFF : (mode == 2) ? 16'h0000
                                      : 16'($urandom_range(1500, 20));
      default:
        return (mode == 1) ? 16'h2000 : (mode == 2) ? 16'h1FFF : 16'($urandom_range(600));
    endcase
  endfunction

  // mostly ranges that pass the window, plus its edges and raw noise
  function automatic logic [15:0] pick_distance();
    int lo, hi;
    lo = int'(min_range) + 51;
    hi = int'(max_range) - 1;
    if (hi > lo + 8000) hi = lo + 8000;
    case ($urandom_range(19))
      0:       return 16'($urandom);
      1:       return 16'(lo - 1);
      2:       return 16'(lo);
      3:       return max_range;
      4:       return max_range - 16'd1;
      default: begin
        if (lo <= hi) return 16'($urandom_range(hi, lo));
        return 16'($urandom);
      end
    endcase
  endfunction

  function automatic plan_step_t cfg_step(input cfg_index_e idx, input logic [15:0] v);
    plan_step_t st;
    st.kind    = STEP_CFG;
    st.reg_idx = idx;
    st.value   = v;
    st.last    = 1'b0;
    st.typed   = 1'b0;
    st.fix     = '0;
    return st;
  endfunction

  function automatic plan_step_t sample_step(input logic [15:0] r, input logic last);
    plan_step_t st;
    st.kind    = STEP_SAMPLE;
    st.reg_idx = CFG_MIN_RANGE;
    st.value   = r;
    st.last    = last;
    st.typed   = 1'b0;
    st.fix     = '0;
    return st;
  endfunction

  // scan end where nothing can be in the gate: (0,0) and found low
  function automatic plan_step_t empty_scan_step(input logic [15:0] r);
    plan_step_t st;
    st = sample_step(r, 1'b1);
    st.typed = 1'b1;
    return st;
  endfunction

  task automatic write_reg(input cfg_index_e idx, input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    apply_reg(idx, v);
  endtask

  task automatic push_sample(input logic [15:0] r, input logic last,
                             input bit typed, input target_fix_t typed_fix);
    int gap;
    target_fix_t fix;
    gap = 0;
    if (!calm) while ($urandom_range(99) < IdlePct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= r;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    sent++;
    if (track_sample(r, last, fix)) queue_target(typed ? typed_fix : fix);
  endtask

  // drain all results, then let a sample still in work finish
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_targets.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (hold_req && hold_count < HoldCycles) begin
      hold_count <= hold_count + 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin : check_targets
    target_fix_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_targets.size() == 0) begin
        note_error($sformatf("unexpected target x=%0d y=%0d found=%0b",
                             $signed(m_tdata[13:0]), $signed(m_tdata[27:14]), m_tuser));
      end else begin
        want = pending_targets.pop_front();
        if (m_tdata[13:0] !== want.x || m_tdata[27:14] !== want.y || m_tuser !== want.found)
          note_error($sformatf("mismatch: want x=%0d y=%0d found=%0b, got x=%0d y=%0d found=%0b",
                               want.x, want.y, want.found, $signed(m_tdata[13:0]),
                               $signed(m_tdata[27:14]), m_tuser));
      end
    end
  end

  initial begin : stimulus
    plan_step_t plan [$];
    target_fix_t none;
    int quota, len;
    none = '0;

    // after reset: nothing in range
    plan = {plan, empty_scan_step(16'd0)};
    // window edges at reset settings
    plan = {plan, sample_step(16'd170, 1'b0)};
    plan = {plan, sample_step(16'd171, 1'b0)};
    plan = {plan, sample_step(16'd65535, 1'b0)};
    plan = {plan, sample_step(16'd11999, 1'b0)};
    plan = {plan, sample_step(16'd12000, 1'b1)};
    // quarter-turn steps from zero, beam angle wraps back to zero
    plan = {plan, cfg_step(CFG_MIN_RANGE, 16'd0)};
    plan = {plan, cfg_step(CFG_MAX_RANGE, 16'hFFFF)};
    plan = {plan, cfg_step(CFG_START_ANGLE, 16'd0)};
    plan = {plan, cfg_step(CFG_ANGLE_STEP, 16'd16384)};
    plan = {plan, cfg_step(CFG_GATE_RADIUS, 16'h3FFF)};
    plan = {plan, cfg_step(CFG_START_X, 16'd250)};
    plan = {plan, cfg_step(CFG_START_Y, 16'd250)};
    plan = {plan, sample_step(16'd51, 1'b0)};
    plan = {plan, sample_step(16'd50, 1'b0)};
    plan = {plan, sample_step(16'd65534, 1'b0)};
    plan = {plan, sample_step(16'd1000, 1'b0)};
    plan = {plan, sample_step(16'd60, 1'b1)};
    // zero gate
    plan = {plan, cfg_step(CFG_GATE_RADIUS, 16'd0)};
    plan = {plan, sample_step(16'd5000, 1'b0)};
    plan = {plan, empty_scan_step(16'd5000)};
    // extreme angles and start point, window closed by the top min range
    plan = {plan, cfg_step(CFG_MIN_RANGE, 16'hFFFF)};
    plan = {plan, cfg_step(CFG_START_ANGLE, 16'h7FFF)};
    plan = {plan, cfg_step(CFG_ANGLE_STEP, 16'h8000)};
    plan = {plan, cfg_step(CFG_GATE_RADIUS, 16'h3FFF)};
    plan = {plan, cfg_step(CFG_START_X, 16'h2000)};
    plan = {plan, cfg_step(CFG_START_Y, 16'h1FFF)};
    plan = {plan, empty_scan_step(16'hFFFF)};
    plan = {plan, cfg_step(CFG_MIN_RANGE, 16'd0)};
    plan = {plan, sample_step(16'hFFFF, 1'b0)};
    plan = {plan, sample_step(16'hFFFE, 1'b0)};
    plan = {plan, sample_step(16'd1, 1'b0)};
    plan = {plan, sample_step(16'd7000, 1'b1)};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        if (i == 0 || plan[i - 1].kind != STEP_CFG) wait_idle();
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        if (cfg_valid) cfg_valid <= 1'b0;
        push_sample(plan[i].value, plan[i].last, plan[i].typed, plan[i].fix);
      end
    end

    for (int phase = 0; sent < ItemsTarget; phase++) begin
      wait_idle();
      calm = (phase == 2) || (phase == 5);
      // hold the output off while samples keep coming, so scan ends back up
      if (phase == 5) hold_req = 1'b1;
      for (int k = 0; k <= int'(CFG_START_Y); k++)
        write_reg(cfg_index_e'(k), pick_reg(cfg_index_e'(k)));
      cfg_valid <= 1'b0;
      quota = sent + $urandom_range(90, 40);
      while (sent < quota) begin
        if (phase == 5) len = $urandom_range(3, 1);
        else if ($urandom_range(9) == 0) len = $urandom_range(30, 11);
        else len = $urandom_range(10, 1);
        for (int k = 1; k <= len; k++) push_sample(pick_distance(), k == len, 1'b0, none);
      end
    end

    wait_idle();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
